// ===== rtl/bte_pkg.sv =====
// ----------------------------------------------------------------------------
// bte_pkg: shared types and constants of the body temperature estimator
// Fixed-point formats, map and correction coefficients, controller states,
// datapath step codes and the command/status bundles.
// ----------------------------------------------------------------------------
package bte_pkg;

   // fixed point
   localparam int FRAC_BITS = 16;
   localparam int COUNT_MAX = 4095;

   localparam int RAW_W   = 16;
   localparam int OUT_W   = 24;
   localparam int SKIN_W  = RAW_W + FRAC_BITS - 7;      // unsigned reading in fixed point
   localparam int STATE_W = SKIN_W + 1;                 // prediction and ramp start
   localparam int A_W     = SKIN_W + 1;                 // |skin - ambient - 2.7|
   localparam int D_W     = A_W + 1;
   localparam int SQ_W    = 2 * A_W - FRAC_BITS;        // square after the shift
   localparam int T_W     = SQ_W + 2;                   // signed working temperature
   localparam int RAMP_W  = SKIN_W + 5;                 // ramp span times numerator
   localparam int DIV_SH  = RAMP_W + 5;                 // reciprocal shift for / 25
   localparam int MA_W    = T_W - 1;                    // multiplier operand a
   localparam int MB_W    = DIV_SH - 4;                 // multiplier operand b
   localparam int P_W     = MA_W + MB_W;
   localparam int SC_W    = P_W - FRAC_BITS;
   localparam int NUM_W   = 5;
   localparam int COUNT_W = $clog2(COUNT_MAX + 1);

   // counter thresholds
   localparam logic [COUNT_W-1:0] COUNT_TOP  = COUNT_W'(COUNT_MAX);
   localparam logic [COUNT_W-1:0] HOLD_COUNT = COUNT_W'(2000);
   localparam logic [COUNT_W-1:0] PREDICT_AT = COUNT_W'(20);
   localparam logic [COUNT_W-1:0] RAMP_MID   = COUNT_W'(25);
   localparam logic [COUNT_W-1:0] RAMP_END   = COUNT_W'(30);

   // temperatures in working format
   localparam logic signed [T_W-1:0] DEG_28 = T_W'(64'sd28 <<< FRAC_BITS);
   localparam logic signed [T_W-1:0] DEG_30 = T_W'(64'sd30 <<< FRAC_BITS);
   localparam logic signed [T_W-1:0] DEG_35 = T_W'(64'sd35 <<< FRAC_BITS);
   localparam logic signed [T_W-1:0] DEG_36 = T_W'(64'sd36 <<< FRAC_BITS);
   localparam logic signed [T_W-1:0] DEG_41 = T_W'(64'sd41 <<< FRAC_BITS);
   localparam logic signed [T_W-1:0] BASE_HI =
      T_W'(((64'sd369 <<< FRAC_BITS) + 64'sd5) / 64'sd10);
   localparam logic signed [T_W-1:0] BASE_MID =
      T_W'(((64'sd362 <<< FRAC_BITS) + 64'sd5) / 64'sd10);
   localparam logic signed [D_W-1:0] OFFSET_2P7 =
      D_W'(((64'sd27 <<< FRAC_BITS) + 64'sd5) / 64'sd10);

   // multiplier coefficients
   localparam logic [MB_W-1:0] COEF_POS  = MB_W'(((64'sd3 <<< FRAC_BITS) + 64'sd10) / 64'sd20);
   localparam logic [MB_W-1:0] COEF_NEG  = MB_W'(((64'sd27 <<< FRAC_BITS) + 64'sd50) / 64'sd100);
   localparam logic [MB_W-1:0] SLOPE_HI  = MB_W'(((64'sd41 <<< FRAC_BITS) + 64'sd25) / 64'sd50);
   localparam logic [MB_W-1:0] SLOPE_MID = MB_W'(((64'sd7 <<< FRAC_BITS) + 64'sd30) / 64'sd60);
   localparam logic [MB_W-1:0] SLOPE_LO  = MB_W'(((64'sd3 <<< FRAC_BITS) + 64'sd2) / 64'sd5);
   localparam logic [MB_W-1:0] RECIP_25  = MB_W'(((64'sd1 <<< DIV_SH) + 64'sd24) / 64'sd25);
   localparam logic [MB_W-1:0] CENTI     = MB_W'(100);

   // output limits
   localparam logic [SC_W-1:0] OUT_MAX_MAG = SC_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
   localparam logic [SC_W-1:0] OUT_MIN_MAG = SC_W'(64'sd1 <<< (OUT_W - 1));
   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_COEF,
      ST_CORR,
      ST_MAP_MUL,
      ST_MAP_ADD,
      ST_RAMP_MUL,
      ST_RAMP_DIV,
      ST_RAMP_ADD,
      ST_SCALE,
      ST_EMIT
   } bte_state_type;

   typedef enum logic [3:0] {
      STEP_NONE,
      STEP_SQUARE,
      STEP_COEF,
      STEP_CORR,
      STEP_MAP_MUL,
      STEP_MAP_ADD,
      STEP_RAMP_MUL,
      STEP_RAMP_DIV,
      STEP_RAMP_ADD,
      STEP_SCALE
   } bte_step_type;

   typedef enum logic [2:0] {
      MODE_ZERO,
      MODE_RAW,
      MODE_PREDICT,
      MODE_RAMP_UP,
      MODE_RAMP_DOWN,
      MODE_MAP
   } bte_mode_type;

   typedef enum logic [1:0] {
      SEG_NONE,
      SEG_LO,
      SEG_MID,
      SEG_HI
   } bte_seg_type;

   typedef struct packed {
      logic         capture;
      bte_step_type step;
      logic         load_out;
   } bte_cmd_type;

   typedef struct packed {
      bte_mode_type mode;
   } bte_status_type;

endpackage

// ===== rtl/bte_if.sv =====
// ----------------------------------------------------------------------------
// bte_if: request and response channels of the body temperature estimator
// Valid/ready channels carrying one reading pair in and one display value out.
// ----------------------------------------------------------------------------
interface bte_req_if import bte_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] skin_raw;
   logic [RAW_W-1:0] ambient_raw;

   modport source (output valid, output skin_raw, output ambient_raw, input ready);
   modport sink (input valid, input skin_raw, input ambient_raw, output ready);
endinterface

interface bte_rsp_if import bte_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] display_centi;

   modport source (output valid, output display_centi, input ready);
   modport sink (input valid, input display_centi, output ready);
endinterface

// ===== rtl/bte_ctrl.sv =====
// ----------------------------------------------------------------------------
// bte_ctrl: sequencing controller
// Walks one item through the shared-multiplier datapath and owns the
// handshake of both channels.
// ----------------------------------------------------------------------------
module bte_ctrl import bte_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  bte_status_type status,
   output bte_cmd_type    cmd
);

   bte_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: state_in = ST_COEF;
         ST_COEF:   state_in = ST_CORR;
         ST_CORR: begin
            unique case (status.mode) inside
               MODE_RAMP_UP, MODE_RAMP_DOWN: state_in = ST_RAMP_MUL;
               MODE_PREDICT, MODE_MAP:       state_in = ST_MAP_MUL;
               default:                      state_in = ST_SCALE;
            endcase
         end
         ST_MAP_MUL:  state_in = ST_MAP_ADD;
         ST_MAP_ADD:  state_in = ST_SCALE;
         ST_RAMP_MUL: state_in = ST_RAMP_DIV;
         ST_RAMP_DIV: state_in = ST_RAMP_ADD;
         ST_RAMP_ADD: state_in = ST_SCALE;
         ST_SCALE:    state_in = ST_EMIT;
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.step     = STEP_NONE;
      unique case (state_ff)
         ST_IDLE:     cmd.capture = req_valid;
         ST_SQUARE:   cmd.step = STEP_SQUARE;
         ST_COEF:     cmd.step = STEP_COEF;
         ST_CORR:     cmd.step = STEP_CORR;
         ST_MAP_MUL:  cmd.step = STEP_MAP_MUL;
         ST_MAP_ADD:  cmd.step = STEP_MAP_ADD;
         ST_RAMP_MUL: cmd.step = STEP_RAMP_MUL;
         ST_RAMP_DIV: cmd.step = STEP_RAMP_DIV;
         ST_RAMP_ADD: cmd.step = STEP_RAMP_ADD;
         ST_SCALE:    cmd.step = STEP_SCALE;
         ST_EMIT:     cmd.load_out = !rsp_valid_ff || rsp_ready;
         default:     cmd.step = STEP_NONE;
      endcase
   end

   // output register holds a finished item until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/bte_dp.sv =====
// ----------------------------------------------------------------------------
// bte_dp: estimator datapath
// Warm counter, correction, piecewise map, ramps and output scaling; the
// multiplying steps share one multiplier whose product is registered.
// ----------------------------------------------------------------------------
module bte_dp import bte_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  bte_cmd_type             cmd,
   output bte_status_type          status,
   input  logic [RAW_W-1:0]        skin_raw,
   input  logic [RAW_W-1:0]        ambient_raw,
   output logic signed [OUT_W-1:0] display_centi
);

   // registers
   logic [SKIN_W-1:0]         skin_ff, skin_in;
   logic [A_W-1:0]            a_ff, a_in;
   logic                      pos_ff, pos_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   bte_mode_type              mode_ff, mode_in;
   logic [NUM_W-1:0]          num_ff, num_in;
   logic [P_W-1:0]            prod_ff, prod_in;
   logic signed [T_W-1:0]     corr_ff, corr_in;
   logic signed [T_W-1:0]     disp_ff, disp_in;
   bte_seg_type               seg_ff, seg_in;
   logic                      neg_ff, neg_in;
   logic signed [STATE_W-1:0] pred_ff, pred_in;
   logic signed [STATE_W-1:0] start_ff, start_in;
   logic signed [OUT_W-1:0]   out_ff, out_in;

   // capture side
   logic [SKIN_W-1:0]     skin_cap;
   logic [SKIN_W-1:0]     amb_cap;
   logic signed [D_W-1:0] d_cap;
   logic                  warm;
   logic [COUNT_W-1:0]    cnt_new;
   bte_mode_type          mode_new;

   // working values
   logic signed [T_W-1:0] skin_t;
   logic signed [T_W-1:0] pred_t;
   logic signed [T_W-1:0] start_t;
   logic signed [T_W-1:0] map_x;
   logic signed [T_W-1:0] seg_at;
   logic signed [T_W-1:0] seg_base;
   logic signed [T_W-1:0] map_val;
   logic signed [T_W-1:0] span;
   logic signed [T_W-1:0] ramp_r;
   logic [MB_W-1:0]       seg_slope;
   bte_seg_type           seg_sel;
   logic [MA_W-1:0]       prod_shr;
   logic [MA_W-1:0]       span_mag;
   logic [MA_W-1:0]       disp_mag;
   logic [RAMP_W-1:0]     quot;
   logic [SC_W-1:0]       scaled;
   logic signed [T_W-1:0] corr_term;

   // shared multiplier
   logic [MA_W-1:0] mul_a;
   logic [MB_W-1:0] mul_b;
   logic [P_W-1:0]  mul_p;

   assign mul_p = {{MB_W{1'b0}}, mul_a} * {{MA_W{1'b0}}, mul_b};

   // counter update and display mode from the incoming reading
   assign skin_cap = {skin_raw, {(FRAC_BITS-7){1'b0}}};
   assign amb_cap  = {ambient_raw, {(FRAC_BITS-7){1'b0}}};
   assign d_cap    = signed'(D_W'(skin_cap)) - signed'(D_W'(amb_cap)) - OFFSET_2P7;
   assign warm     = signed'(T_W'(skin_cap)) > DEG_28;

   always_comb begin
      if (warm) begin
         cnt_new = (count_ff < COUNT_TOP) ? count_ff + 1'b1 : COUNT_TOP;
      end else if (count_ff == HOLD_COUNT) begin
         cnt_new = count_ff;
      end else begin
         cnt_new = '0;
      end

      if (cnt_new == '0) begin
         mode_new = MODE_ZERO;
      end else if (cnt_new < PREDICT_AT) begin
         mode_new = MODE_RAW;
      end else if (cnt_new == PREDICT_AT) begin
         mode_new = MODE_PREDICT;
      end else if (cnt_new <= RAMP_MID) begin
         mode_new = MODE_RAMP_UP;
      end else if (cnt_new <= RAMP_END) begin
         mode_new = MODE_RAMP_DOWN;
      end else begin
         mode_new = MODE_MAP;
      end
   end

   assign skin_t   = signed'(T_W'(skin_ff));
   assign pred_t   = T_W'(pred_ff);
   assign start_t  = T_W'(start_ff);
   assign prod_shr = prod_ff[FRAC_BITS +: MA_W];
   assign corr_term = signed'(T_W'(prod_ff[FRAC_BITS +: SQ_W]));

   // piecewise-linear map
   assign map_x = (mode_ff == MODE_PREDICT) ? skin_t : corr_ff;

   always_comb begin
      if (map_x > DEG_36 && map_x <= DEG_41) begin
         seg_sel = SEG_HI;
      end else if (map_x > DEG_30 && map_x <= DEG_36) begin
         seg_sel = SEG_MID;
      end else if (map_x > DEG_28 && map_x <= DEG_30) begin
         seg_sel = SEG_LO;
      end else begin
         seg_sel = SEG_NONE;
      end
   end

   always_comb begin
      case (seg_sel)
         SEG_HI: begin
            seg_at    = DEG_36;
            seg_slope = SLOPE_HI;
         end
         SEG_MID: begin
            seg_at    = DEG_30;
            seg_slope = SLOPE_MID;
         end
         default: begin
            seg_at    = DEG_28;
            seg_slope = SLOPE_LO;
         end
      endcase
   end

   always_comb begin
      case (seg_ff)
         SEG_HI:  seg_base = BASE_HI;
         SEG_MID: seg_base = BASE_MID;
         default: seg_base = DEG_35;
      endcase
   end

   assign map_val = (seg_ff == SEG_NONE) ? map_x : seg_base + signed'({1'b0, prod_shr});

   // ramp toward the prediction
   assign span     = pred_t - start_t;
   assign span_mag = MA_W'((span < 0) ? -span : span);
   assign quot     = prod_ff[DIV_SH +: RAMP_W];
   assign ramp_r   = neg_ff ? -signed'(T_W'(quot)) : signed'(T_W'(quot));

   // output scaling
   assign disp_mag = MA_W'((disp_ff < 0) ? -disp_ff : disp_ff);
   assign scaled   = prod_ff[P_W-1:FRAC_BITS];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.step)
         STEP_SQUARE: begin
            mul_a = MA_W'(a_ff);
            mul_b = MB_W'(a_ff);
         end
         STEP_COEF: begin
            mul_a = MA_W'(prod_ff[FRAC_BITS +: SQ_W]);
            mul_b = pos_ff ? COEF_POS : COEF_NEG;
         end
         STEP_MAP_MUL: begin
            mul_a = MA_W'(map_x - seg_at);
            mul_b = seg_slope;
         end
         STEP_RAMP_MUL: begin
            mul_a = span_mag;
            mul_b = MB_W'(num_ff);
         end
         STEP_RAMP_DIV: begin
            // divide by 25 through a reciprocal, exact below 2**RAMP_W
            mul_a = MA_W'(prod_ff[RAMP_W-1:0]);
            mul_b = RECIP_25;
         end
         STEP_SCALE: begin
            mul_a = disp_mag;
            mul_b = CENTI;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      skin_in  = skin_ff;
      a_in     = a_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      mode_in  = mode_ff;
      num_in   = num_ff;
      prod_in  = prod_ff;
      corr_in  = corr_ff;
      disp_in  = disp_ff;
      seg_in   = seg_ff;
      neg_in   = neg_ff;
      pred_in  = pred_ff;
      start_in = start_ff;
      out_in   = out_ff;

      if (cmd.capture) begin
         skin_in  = skin_cap;
         a_in     = A_W'((d_cap < 0) ? -d_cap : d_cap);
         pos_in   = d_cap > 0;
         count_in = cnt_new;
         mode_in  = mode_new;
         if (mode_new == MODE_RAMP_UP) begin
            num_in = NUM_W'((cnt_new - PREDICT_AT) << 2);
         end else begin
            num_in = NUM_W'(RAMP_END - cnt_new);
         end
         if (mode_new == MODE_ZERO) begin
            pred_in = '0;
         end
      end

      case (cmd.step)
         STEP_SQUARE, STEP_COEF, STEP_RAMP_MUL, STEP_RAMP_DIV: begin
            prod_in = mul_p;
            if (cmd.step == STEP_RAMP_MUL) begin
               neg_in = span < 0;
            end
         end
         STEP_CORR: begin
            corr_in = pos_ff ? skin_t + corr_term : skin_t - corr_term;
            disp_in = skin_t;
         end
         STEP_MAP_MUL: begin
            prod_in = mul_p;
            seg_in  = seg_sel;
         end
         STEP_MAP_ADD: begin
            if (mode_ff == MODE_PREDICT) begin
               pred_in  = STATE_W'(map_val);
               start_in = STATE_W'(skin_t);
            end else begin
               disp_in = map_val;
            end
         end
         STEP_RAMP_ADD: begin
            disp_in = (mode_ff == MODE_RAMP_UP) ? start_t + ramp_r : pred_t - ramp_r;
         end
         STEP_SCALE: begin
            prod_in = mul_p;
            neg_in  = disp_ff < 0;
         end
         default: begin
         end
      endcase

      if (cmd.load_out) begin
         if (neg_ff) begin
            out_in = (scaled > OUT_MIN_MAG) ? OUT_MIN : signed'(OUT_W'(-scaled));
         end else begin
            out_in = (scaled > OUT_MAX_MAG) ? OUT_MAX : signed'(OUT_W'(scaled));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mode_ff  <= MODE_ZERO;
         pred_ff  <= '0;
         start_ff <= '0;
      end else begin
         count_ff <= count_in;
         mode_ff  <= mode_in;
         pred_ff  <= pred_in;
         start_ff <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      skin_ff <= skin_in;
      a_ff    <= a_in;
      pos_ff  <= pos_in;
      num_ff  <= num_in;
      prod_ff <= prod_in;
      corr_ff <= corr_in;
      disp_ff <= disp_in;
      seg_ff  <= seg_in;
      neg_ff  <= neg_in;
      out_ff  <= out_in;
   end

   assign status.mode   = mode_ff;
   assign display_centi = out_ff;

   // ramp span stays within a reading, which keeps the reciprocal divide exact
   a_span_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.step == STEP_RAMP_MUL |-> span_mag < (MA_W'(1) << SKIN_W))
      else $error("ramp span exceeds reading range");

   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.step == STEP_RAMP_ADD |-> MA_W'(quot) <= span_mag)
      else $error("ramp step larger than span");

   a_seg_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.step == STEP_MAP_ADD && seg_ff != SEG_NONE |->
         prod_shr < (MA_W'(1) << (FRAC_BITS + 3)))
      else $error("map segment offset out of range");

   a_zero_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.capture && cnt_new == '0 |=> pred_ff == '0 && count_ff == '0)
      else $error("cool sample did not clear prediction");

endmodule

// ===== rtl/body_temperature_estimator.sv =====
// Each item steps through capture, square, coefficient and correction, then the
// map multiply and add, the ramp multiply, divide and add, or neither, then scaling and emit.
// The single shared multiplier takes one item at a time: a new reading is accepted
// only once the last one has been loaded into the output register.
// A finished item waits in the output register while the next one is taken.
// Reset (synchronous, active high) clears counter, prediction, ramp start and valid.
// ----------------------------------------------------------------------------
// body_temperature_estimator: top level
// Joins the sequencing controller and the datapath to the two channels.
// ----------------------------------------------------------------------------
module body_temperature_estimator import bte_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   bte_req_if.sink      req_if,
   bte_rsp_if.source    rsp_if
);

   bte_cmd_type    cmd;
   bte_status_type status;

   bte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bte_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .skin_raw      (req_if.skin_raw),
      .ambient_raw   (req_if.ambient_raw),
      .display_centi (rsp_if.display_centi)
   );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for body_temperature_estimator
// Feeds skin/ambient reading pairs through the request channel and checks
// every displayed temperature against an in-bench estimate that tracks the
// warm-sample counter, the prediction taken at sample 20, both ramps and
// the mapped, corrected skin value. Both channels idle at random, with a
// calm stretch and a long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module testbench;
   import bte_pkg::*;

   localparam int     RAW_SHIFT        = FRAC_BITS - 7;
   localparam longint ONE_DEG          = 64'sd1 <<< FRAC_BITS;
   localparam int     WARM_HOLD        = 2000;
   localparam int     PREDICT_COUNT    = 20;
   localparam int     RAMP_UP_END      = 25;
   localparam int     RAMP_DOWN_END    = 30;
   localparam int     RAW_PER_DEG      = 128;
   localparam int     COOL_RAW_MAX     = 28 * RAW_PER_DEG;
   localparam int     WARM_RAW_MIN     = COOL_RAW_MAX + 1;
   localparam int     BODY_RAW_MAX     = 42 * RAW_PER_DEG;
   localparam int     RAW_MAX          = (1 << RAW_W) - 1;
   localparam int     SKIN_LEAD_RAW    = 346;            // 2.7 degC in counts
   localparam longint OUT_TOP          = (64'sd1 <<< (OUT_W - 1)) - 1;
   localparam int     MISMATCH_REPORTS = 10;
   localparam longint LIMIT_CYCLES     = 1_000_000;
   localparam int     RANDOM_ITEMS     = 150;
   localparam int     HOLD_OFF_CYCLES  = 300;
   localparam int     DRAIN_CYCLES     = 30;

   class display_tracker;
      int unsigned             warm_count = 0;
      longint                  predicted  = 0;
      longint                  ramp_start = 0;
      logic signed [OUT_W-1:0] expected_display [$];
      int unsigned             mismatches   = 0;
      int unsigned             results_seen = 0;
      int unsigned             held_hits    = 0;
      int unsigned             ceiling_hits = 0;
      int unsigned             mode_hits [MODE_ZERO:MODE_MAP];

      function longint fixed_ratio(input longint num, input longint den);
         return ((num <<< FRAC_BITS) + den / 2) / den;
      endfunction

      function longint on_line(input longint x, input longint base, input longint at,
                               input longint slope);
         return base + (((x - at) * slope) >>> FRAC_BITS);
      endfunction

      function longint body_map(input longint x);
         if (x > 36 * ONE_DEG && x <= 41 * ONE_DEG)
            return on_line(x, fixed_ratio(369, 10), 36 * ONE_DEG, fixed_ratio(41, 50));
         if (x > 30 * ONE_DEG && x <= 36 * ONE_DEG)
            return on_line(x, fixed_ratio(362, 10), 30 * ONE_DEG, fixed_ratio(7, 60));
         if (x > 28 * ONE_DEG && x <= 30 * ONE_DEG)
            return on_line(x, 35 * ONE_DEG, 28 * ONE_DEG, fixed_ratio(3, 5));
         return x;
      endfunction

      // span * num / 25, truncated toward zero
      function longint ramp_share(input longint span, input longint num);
         longint part;
         part = ((span < 0 ? -span : span) * num) / 25;
         return span < 0 ? -part : part;
      endfunction

      function logic signed [OUT_W-1:0] estimate_display(input logic [RAW_W-1:0] skin_raw,
                                                         input logic [RAW_W-1:0] ambient_raw);
         longint       skin, ambient, offset, gap, square, corrected, shown, mag;
         bte_mode_type mode;
         skin    = longint'(skin_raw) <<< RAW_SHIFT;
         ambient = longint'(ambient_raw) <<< RAW_SHIFT;
         offset  = skin - ambient - fixed_ratio(27, 10);
         gap     = offset < 0 ? -offset : offset;
         square  = (gap * gap) >>> FRAC_BITS;
         if (offset > 0) begin
            corrected = skin + ((square * fixed_ratio(3, 20)) >>> FRAC_BITS);
         end else begin
            corrected = skin - ((square * fixed_ratio(27, 100)) >>> FRAC_BITS);
         end

         if (skin > 28 * ONE_DEG) begin
            if (warm_count < COUNT_MAX) warm_count++;
            else ceiling_hits++;
         end else if (warm_count != WARM_HOLD) begin
            warm_count = 0;
         end else begin
            held_hits++;
         end

         if (warm_count == 0) begin
            mode      = MODE_ZERO;
            shown     = skin;
            predicted = 0;
         end else if (warm_count < PREDICT_COUNT) begin
            mode  = MODE_RAW;
            shown = skin;
         end else if (warm_count == PREDICT_COUNT) begin
            mode       = MODE_PREDICT;
            shown      = skin;
            ramp_start = skin;
            predicted  = body_map(skin);
         end else if (warm_count <= RAMP_UP_END) begin
            mode  = MODE_RAMP_UP;
            shown = ramp_start + ramp_share(predicted - ramp_start,
                                            longint'(warm_count - PREDICT_COUNT) * 4);
         end else if (warm_count <= RAMP_DOWN_END) begin
            mode  = MODE_RAMP_DOWN;
            shown = predicted - ramp_share(predicted - ramp_start,
                                           longint'(RAMP_DOWN_END - warm_count));
         end else begin
            mode  = MODE_MAP;
            shown = body_map(corrected);
         end
         mode_hits[mode]++;

         mag = ((shown < 0 ? -shown : shown) * 100) >>> FRAC_BITS;
         if (shown < 0) begin
            if (mag > OUT_TOP + 1) return OUT_MIN;
            return OUT_W'(-mag);
         end
         if (mag > OUT_TOP) return OUT_MAX;
         return OUT_W'(mag);
      endfunction

      function void note_reading(input logic [RAW_W-1:0] skin_raw,
                                 input logic [RAW_W-1:0] ambient_raw);
         expected_display.push_back(estimate_display(skin_raw, ambient_raw));
      endfunction

      function void check_display(input logic signed [OUT_W-1:0] got);
         logic signed [OUT_W-1:0] want;
         results_seen++;
         if (expected_display.size() == 0) begin
            mismatches++;
            if (mismatches <= MISMATCH_REPORTS)
               $display("display %0d arrived with no reading pending", got);
            return;
         end
         want = expected_display.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= MISMATCH_REPORTS)
               $display("display mismatch on item %0d: expected %0d, got %0d",
                        results_seen, want, got);
         end
      endfunction
   endclass

   logic   clock    = 1'b0;
   logic   reset    = 1'b1;
   logic   calm     = 1'b0;
   logic   hold_off = 1'b0;
   int     items_sent  = 0;
   longint cycle_count = 0;

   display_tracker tracker = new;

   bte_req_if req_bus ();
   bte_rsp_if rsp_bus ();

   body_temperature_estimator dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("no progress within %0d cycles", cycle_count);
         $display("body_temperature_estimator verification failed");
         $finish;
      end
   end

   // ---- stimulus helpers

   task automatic send_reading(input logic [RAW_W-1:0] skin_raw,
                               input logic [RAW_W-1:0] ambient_raw);
      while (!calm && $urandom_range(99) < 38) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.skin_raw    <= skin_raw;
      req_bus.ambient_raw <= ambient_raw;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_reading(skin_raw, ambient_raw);
      items_sent++;
   endtask

   function automatic logic [RAW_W-1:0] ambient_near(input logic [RAW_W-1:0] skin_raw);
      int level;
      level = int'(skin_raw) - SKIN_LEAD_RAW + int'($urandom_range(1200)) - 600;
      if (level < 0) level = 0;
      else if (level > RAW_MAX) level = RAW_MAX;
      return RAW_W'(level);
   endfunction

   // readings right at and around the map breakpoints, or full scale
   function automatic logic [RAW_W-1:0] boundary_skin();
      case ($urandom_range(10))
         0:       return RAW_W'(WARM_RAW_MIN);
         1:       return RAW_W'(30 * RAW_PER_DEG - 1);
         2:       return RAW_W'(30 * RAW_PER_DEG);
         3:       return RAW_W'(30 * RAW_PER_DEG + 1);
         4:       return RAW_W'(36 * RAW_PER_DEG - 1);
         5:       return RAW_W'(36 * RAW_PER_DEG);
         6:       return RAW_W'(36 * RAW_PER_DEG + 1);
         7:       return RAW_W'(41 * RAW_PER_DEG - 1);
         8:       return RAW_W'(41 * RAW_PER_DEG);
         9:       return RAW_W'(41 * RAW_PER_DEG + 1);
         default: return RAW_W'(RAW_MAX);
      endcase
   endfunction

   task automatic pick_warm(output logic [RAW_W-1:0] skin_raw,
                            output logic [RAW_W-1:0] ambient_raw);
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: begin
            skin_raw    = RAW_W'($urandom_range(BODY_RAW_MAX, WARM_RAW_MIN));
            ambient_raw = ambient_near(skin_raw);
         end
         6: begin
            skin_raw    = RAW_W'($urandom_range(BODY_RAW_MAX, WARM_RAW_MIN));
            ambient_raw = RAW_W'($urandom);
         end
         7: begin
            skin_raw    = RAW_W'($urandom_range(RAW_MAX, WARM_RAW_MIN));
            ambient_raw = RAW_W'($urandom);
         end
         8: begin
            skin_raw    = boundary_skin();
            ambient_raw = ambient_near(skin_raw);
         end
         default: begin
            skin_raw    = RAW_W'($urandom_range(RAW_MAX, WARM_RAW_MIN));
            ambient_raw = ambient_near(skin_raw);
         end
      endcase
   endtask

   task automatic send_cool();
      logic [RAW_W-1:0] skin_raw;
      skin_raw = ($urandom_range(9) == 0) ? RAW_W'(COOL_RAW_MAX)
                                          : RAW_W'($urandom_range(COOL_RAW_MAX));
      send_reading(skin_raw, RAW_W'($urandom));
   endtask

   task automatic warm_run(input int length);
      logic [RAW_W-1:0] skin_raw, ambient_raw;
      for (int i = 0; i < length; i++) begin
         // the reading that fixes the prediction often sits on a breakpoint
         if (i == PREDICT_COUNT - 1 && $urandom_range(1)) begin
            skin_raw    = boundary_skin();
            ambient_raw = ambient_near(skin_raw);
         end else begin
            pick_warm(skin_raw, ambient_raw);
         end
         send_reading(skin_raw, ambient_raw);
      end
   endtask

   // ---- request side

   initial begin : stimulus
      int random_start;
      req_bus.valid       <= 1'b0;
      req_bus.skin_raw    <= '0;
      req_bus.ambient_raw <= '0;
      while (reset) @(posedge clock);

      send_reading(16'h0000, 16'h0000);
      send_reading(16'hFFFF, 16'h0000);
      send_reading(16'h0000, 16'hFFFF);
      send_reading(16'hFFFF, 16'hFFFF);
      send_reading(RAW_W'(COOL_RAW_MAX), 16'h0000);
      send_reading(RAW_W'(WARM_RAW_MIN), 16'hFFFF);
      send_reading(16'h5555, 16'hAAAA);
      send_reading(16'hAAAA, 16'h5555);
      send_reading(RAW_W'(COOL_RAW_MAX), 16'hFFFF);
      warm_run(RAMP_DOWN_END + 3);
      send_cool();

      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         calm <= (items_sent - random_start >= 40) && (items_sent - random_start < 120);
         case ($urandom_range(19))
            0, 1, 2: repeat ($urandom_range(8, 1))
                        send_reading(RAW_W'($urandom), RAW_W'($urandom));
            3, 4:    warm_run($urandom_range(25, 1));
            default: warm_run($urandom_range(45, 18));
         endcase
         repeat ($urandom_range(3, 1)) send_cool();
      end
      calm <= 1'b0;

      // long warm stretch up to the hold point, held through cool readings, then warm, clear and warm again
      warm_run(WARM_HOLD);
      repeat (3) send_cool();
      warm_run(4);
      send_cool();
      warm_run(4);

      req_bus.valid <= 1'b0;
      while (tracker.expected_display.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d items: %0d zero, %0d raw, %0d predict, %0d up, %0d down, %0d mapped",
               items_sent, tracker.mode_hits[MODE_ZERO], tracker.mode_hits[MODE_RAW],
               tracker.mode_hits[MODE_PREDICT], tracker.mode_hits[MODE_RAMP_UP],
               tracker.mode_hits[MODE_RAMP_DOWN], tracker.mode_hits[MODE_MAP]);
      $display("counter held %0d times, at ceiling %0d times; %0d displays, %0d mismatches",
               tracker.held_hits, tracker.ceiling_hits, tracker.results_seen,
               tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.expected_display.size() == 0) begin
         $display("body_temperature_estimator verification clean");
      end else begin
         $display("body_temperature_estimator verification failed");
      end
      $finish;
   end

   // ---- result side

   initial begin : receiver_hold
      wait (items_sent >= 150);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin : receiver
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            tracker.check_display(rsp_bus.display_centi);
         if (hold_off) begin
            rsp_bus.ready <= 1'b0;
         end else if (calm) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= 38);
         end
      end
   end

endmodule
